>>> src/plfe_pkg.sv
// Shared types, codes and constants of the palette linear fade engine.
package plfe_pkg;

    localparam int CH_W       = 5;
    localparam int NUM_CH     = 3;
    localparam int COLOUR_W   = CH_W * NUM_CH;
    localparam int FP_W       = 16;
    localparam int FP_SHIFT   = 8;
    localparam int IDX_W      = 8;
    localparam int FRAMES_W   = 15;
    localparam int MASK_W     = 16;
    localparam int NUM_GROUPS = MASK_W;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CH_SEL_W   = 2;

    localparam int DIV_NUM_W = CH_W + FP_SHIFT;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
    localparam int DIV_REM_W = FRAMES_W + 1;

    localparam logic [CH_W-1:0]     CH_MAX    = 5'h1F;
    localparam logic [FP_W-1:0]     CH_MAX_FP = 16'h1F00;
    localparam logic [CH_SEL_W-1:0] LAST_CH   = 2'd2;

    typedef logic [CH_W-1:0]             t_chan;
    typedef logic [NUM_CH-1:0][CH_W-1:0] t_colour;
    typedef logic [FP_W-1:0]             t_fp;
    typedef logic [NUM_CH-1:0][FP_W-1:0] t_fp3;

    typedef enum logic [1:0] {
        OP_LOAD_CUR = 2'd0,
        OP_LOAD_TGT = 2'd1,
        OP_PREPARE  = 2'd2,
        OP_STEP     = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FADE_FRAMES = 1'd0,
        CFG_GROUP_MASK  = 1'd1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_DIV_GO,
        S_DIV_WAIT,
        S_STEP,
        S_WB,
        S_DONE
    } t_state;

    typedef struct packed {
        t_opcode              opcode;
        logic [IDX_W-1:0]     entry_index;
        logic [COLOUR_W-1:0]  colour_in;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]     entry_out;
        logic [COLOUR_W-1:0]  colour_out;
    } t_out_item;

    typedef struct packed {
        logic                  start;
        logic                  neg;
        logic [DIV_NUM_W-1:0]  num;
        logic [FRAMES_W-1:0]   den;
    } t_div_req;

    typedef struct packed {
        logic      done;
        t_fp       quot;
    } t_div_rsp;

endpackage

>>> src/plfe_stream_if.sv
// Valid/ready stream channel carrying one payload per transfer.
interface plfe_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> src/plfe_div.sv
// Restoring divider for slope computation, one quotient bit per cycle.
module plfe_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  plfe_pkg::t_div_req i_req,
    output plfe_pkg::t_div_rsp o_rsp
);
    import plfe_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_REM_W-1:0] r_rem;
    logic [DIV_NUM_W-1:0] r_num;
    logic                 r_neg;
    logic [FRAMES_W-1:0]  r_den;

    logic [DIV_REM_W-1:0] trial;
    logic [DIV_REM_W-1:0] trial_sub;
    logic                 trial_ge;

    always_comb begin
        trial     = {r_rem[DIV_REM_W-2:0], r_num[DIV_NUM_W-1]};
        trial_ge  = trial >= {1'b0, r_den};
        trial_sub = trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_NUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_num <= i_req.num;
            r_neg <= i_req.neg;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= trial_ge ? trial_sub : trial;
            r_num <= {r_num[DIV_NUM_W-2:0], trial_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_neg ? (FP_W'(0) - FP_W'(r_num)) : FP_W'(r_num);

endmodule

>>> src/plfe_step_alu.sv
// One-channel frame step: wrap add of slope, clamp and channel extract.
module plfe_step_alu (
    input  plfe_pkg::t_fp   i_acc,
    input  plfe_pkg::t_fp   i_slope,
    output plfe_pkg::t_fp   o_acc,
    output plfe_pkg::t_fp   o_slope,
    output plfe_pkg::t_chan o_chan
);
    import plfe_pkg::*;

    t_fp sum;

    always_comb begin
        sum     = i_acc + i_slope;
        o_acc   = sum;
        o_slope = i_slope;
        if (sum[FP_W-1]) begin
            o_acc   = '0;
            o_slope = '0;
        end else if (sum[FP_SHIFT +: CH_W] == CH_MAX) begin
            o_acc   = CH_MAX_FP;
            o_slope = '0;
        end
        o_chan = o_acc[FP_SHIFT +: CH_W];
    end

endmodule

>>> src/palette_linear_fade_engine.sv
// Top level of the palette linear fade engine: sequencer, palette stores, config.
//
//   channel    dir  payload                               handshake
//   i_item     in   opcode, entry_index, colour_in        valid/ready
//   o_result   out  entry_out, colour_out                 valid/ready
//   i_cfg_*    in   register index, write data            write enable
//
// Path from transfer in to result register: a load runs S_FETCH and S_DONE; a step
// runs S_FETCH, S_STEP per channel, S_WB and S_DONE; a prepare runs S_FETCH, then
// S_DIV_GO and S_DIV_WAIT per channel on the shared serial divider, S_WB, S_DONE.
// Step runs the three channels through one adder/clamp unit, one per cycle.
// Reset clears the sequencer and both config registers; palette stores are not cleared.
// A result stalled at the output holds only the output register; the next item
// is taken meanwhile, and a finished item waits in S_DONE until the register frees.
module palette_linear_fade_engine #(
    parameter int PALETTE_ENTRIES = 256,
    parameter int GROUP_SIZE      = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    plfe_stream_if.sink                           i_item,
    plfe_stream_if.source                         o_result,
    input  logic                                  i_cfg_we,
    input  logic [plfe_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [plfe_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);
    import plfe_pkg::*;

    localparam int AW = $clog2(PALETTE_ENTRIES);

    t_state                r_state;
    t_state                n_state;
    logic [CH_SEL_W-1:0]   r_ch;

    t_opcode               r_op;
    logic [IDX_W-1:0]      r_idx;
    logic [AW-1:0]         r_addr;
    logic                  r_in_range;
    t_colour               r_colour_in;

    logic [FRAMES_W-1:0]   r_fade_frames;
    logic [MASK_W-1:0]     r_group_mask;

    t_colour               r_cur_mem [PALETTE_ENTRIES];
    t_colour               r_tgt_mem [PALETTE_ENTRIES];
    t_fp3                  r_slope_mem [PALETTE_ENTRIES];
    t_fp3                  r_acc_mem [PALETTE_ENTRIES];

    t_colour               r_cur_q;
    t_colour               r_tgt_q;
    t_fp3                  r_slope_q;
    t_fp3                  r_acc_q;

    t_fp3                  r_new_slope;
    t_fp3                  r_new_acc;
    t_colour               r_new_colour;
    t_colour               r_res_colour;

    logic                  r_out_valid;
    t_out_item             r_out_item;

    logic                  accept;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  in_range;
    logic                  fades;
    logic                  out_free;
    logic                  item_ready;
    logic                  cur_we;
    t_colour               cur_wd;
    logic                  tgt_we;
    logic                  sa_we;
    t_colour               fetch_colour;

    t_chan                 cur_c;
    t_chan                 tgt_c;
    t_chan                 mag;
    t_fp                   slope_sel;
    t_div_req              div_req;
    t_div_rsp              div_rsp;

    t_fp                   alu_acc;
    t_fp                   alu_slope;
    t_chan                 alu_chan;

    assign accept   = i_item.valid && item_ready;
    assign rd_en    = accept;
    assign rd_addr  = AW'(i_item.payload.entry_index);
    assign in_range = 32'(i_item.payload.entry_index) < PALETTE_ENTRIES;
    assign out_free = !r_out_valid || o_result.ready;

    assign i_item.ready     = item_ready;
    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out_item;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_frames <= '0;
            r_group_mask  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FADE_FRAMES: r_fade_frames <= i_cfg_wdata[FRAMES_W-1:0];
                CFG_GROUP_MASK:  r_group_mask  <= i_cfg_wdata[MASK_W-1:0];
            endcase
        end
    end

    always_comb begin
        fades = 1'b0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            if (r_group_mask[g] && (32'(r_idx) >= g * GROUP_SIZE) &&
                (32'(r_idx) < (g + 1) * GROUP_SIZE)) begin
                fades = 1'b1;
            end
        end
    end

    // shared units
    always_comb begin
        cur_c = r_cur_q[r_ch];
        tgt_c = r_tgt_q[r_ch];
        mag   = (tgt_c < cur_c) ? (cur_c - tgt_c) : (tgt_c - cur_c);
        slope_sel = ((r_fade_frames == '0) || !fades) ? '0 : div_rsp.quot;
    end

    assign div_req.start = (r_state == S_DIV_GO);
    assign div_req.neg   = tgt_c < cur_c;
    assign div_req.num   = {mag, {FP_SHIFT{1'b0}}};
    assign div_req.den   = r_fade_frames;

    plfe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    plfe_step_alu u_step_alu (
        .i_acc   (r_acc_q[r_ch]),
        .i_slope (r_slope_q[r_ch]),
        .o_acc   (alu_acc),
        .o_slope (alu_slope),
        .o_chan  (alu_chan)
    );

    // sequencer: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                if (!r_in_range) begin
                    n_state = S_DONE;
                end else begin
                    unique case (r_op) inside
                        OP_LOAD_CUR, OP_LOAD_TGT: n_state = S_DONE;
                        OP_PREPARE:               n_state = S_DIV_GO;
                        OP_STEP:                  n_state = S_STEP;
                    endcase
                end
            end
            S_DIV_GO: begin
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    n_state = (r_ch == LAST_CH) ? S_WB : S_DIV_GO;
                end
            end
            S_STEP: begin
                if (r_ch == LAST_CH) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // sequencer: outputs
    always_comb begin
        item_ready   = 1'b0;
        cur_we       = 1'b0;
        cur_wd       = r_new_colour;
        tgt_we       = 1'b0;
        sa_we        = 1'b0;
        fetch_colour = r_cur_q;
        unique case (r_state)
            S_IDLE: begin
                item_ready = i_rst_n;
            end
            S_FETCH: begin
                if (!r_in_range) begin
                    fetch_colour = '0;
                end else if (r_op == OP_LOAD_CUR) begin
                    cur_we       = 1'b1;
                    cur_wd       = r_colour_in;
                    fetch_colour = r_colour_in;
                end else if (r_op == OP_LOAD_TGT) begin
                    tgt_we = 1'b1;
                end
            end
            S_WB: begin
                sa_we  = 1'b1;
                cur_we = (r_op == OP_STEP);
            end
            S_DIV_GO, S_DIV_WAIT, S_STEP, S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FETCH) begin
                r_ch <= '0;
            end else if ((r_state == S_STEP) ||
                         ((r_state == S_DIV_WAIT) && div_rsp.done)) begin
                r_ch <= r_ch + 1'b1;
            end
        end
    end

    // item capture and per-channel results
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op        <= i_item.payload.opcode;
            r_idx       <= i_item.payload.entry_index;
            r_addr      <= rd_addr;
            r_in_range  <= in_range;
            r_colour_in <= t_colour'(i_item.payload.colour_in);
        end
        if (r_state == S_STEP) begin
            r_new_acc[r_ch]    <= alu_acc;
            r_new_slope[r_ch]  <= alu_slope;
            r_new_colour[r_ch] <= alu_chan;
        end
        if ((r_state == S_DIV_WAIT) && div_rsp.done) begin
            r_new_slope[r_ch] <= slope_sel;
            r_new_acc[r_ch]   <= {{(FP_W - CH_W - FP_SHIFT){1'b0}}, cur_c,
                                  {FP_SHIFT{1'b0}}};
        end
        if (r_state == S_FETCH) begin
            r_res_colour <= fetch_colour;
        end else if ((r_state == S_WB) && (r_op == OP_STEP)) begin
            r_res_colour <= r_new_colour;
        end
    end

    // palette stores
    always_ff @(posedge i_clk) begin
        if (cur_we) begin
            r_cur_mem[r_addr] <= cur_wd;
        end
        if (rd_en) begin
            r_cur_q <= r_cur_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tgt_we) begin
            r_tgt_mem[r_addr] <= r_colour_in;
        end
        if (rd_en) begin
            r_tgt_q <= r_tgt_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (sa_we) begin
            r_slope_mem[r_addr] <= r_new_slope;
        end
        if (rd_en) begin
            r_slope_q <= r_slope_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (sa_we) begin
            r_acc_mem[r_addr] <= r_new_acc;
        end
        if (rd_en) begin
            r_acc_q <= r_acc_mem[rd_addr];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_out_item.entry_out  <= r_idx;
            r_out_item.colour_out <= r_res_colour;
        end
    end

`ifndef ASSERT_OFF
    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV_WAIT))
        else $error("divider finished outside the wait state");

    a_accept_to_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_FETCH))
        else $error("transfer in not followed by fetch");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cur_we || tgt_we || sa_we) |-> r_in_range)
        else $error("store write for an out-of-range entry");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result register loaded outside the done state");
`endif

endmodule
